/* design/lfw_pkg.sv */
`default_nettype none
package lfw_pkg;

  // character codes
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_SPACE   = 8'd32;

  // register file
  localparam int FOLD_WIDTH_W = 6;
  localparam int TAB_SPAN_W   = 5;
  localparam int CFG_DATA_W   = 6;
  localparam int CFG_INDEX_W  = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_FOLD_WIDTH = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_TAB_SPAN   = 1'b1;

  localparam logic [FOLD_WIDTH_W-1:0] FOLD_WIDTH_RESET = 6'd10;
  localparam logic [TAB_SPAN_W-1:0]   TAB_SPAN_RESET   = 5'd8;

  // limits applied to the register values
  localparam int WIDTH_MIN = 2;
  localparam int TAB_MIN   = 1;
  localparam int TAB_MAX   = 16;

  // working width for column sums (count + tab stays below 2**ARITH_W)
  localparam int ARITH_W = 8;

  localparam int DEF_BUF_DEPTH = 64;

endpackage
`default_nettype wire

/* design/line_fold_word_wrap.sv */
// greedy line folder. each request carries one text byte, or an end-of-input
// flag that flushes the pending line. lines are folded at fold_width
// columns (held between 2 and BUF_DEPTH): the line goes out up to and
// including its last blank, or whole if it has none, then a newline, and
// the characters after that blank stay pending. a tab becomes tab_span
// spaces (held between 1 and 16); a tab that reaches the width is padded
// to the width and the line goes out. newline or end-of-input flushes the
// pending characters; with nothing pending it produces nothing. every
// result carries one byte; last_of_run marks the newline that closes the
// results of a request. an ordinary byte is written to the store as it is
// taken; a tab is written as its spaces one by one, as the character store
// has a single write port, and the input waits meanwhile. folded lines are
// read back one character per cycle while out_ready holds, through the
// store's read port, then the newline, while the input carries on behind a
// two-entry line queue. the input also stalls while the queue is full, or
// while unread and pending characters fill the BUF_DEPTH-entry store.
`default_nettype none
module line_fold_word_wrap #(
  parameter int BUF_DEPTH = lfw_pkg::DEF_BUF_DEPTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // configuration writes
  input  wire logic                              cfg_write,
  input  wire logic [lfw_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [lfw_pkg::CFG_DATA_W-1:0]    cfg_data,
  // input requests
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [7:0]                        char_in,
  input  wire logic                              end_of_input,
  // results
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic      [7:0]                        char_out,
  output logic                                   last_of_run
);

  localparam int PW = $clog2(BUF_DEPTH);
  localparam int CW = $clog2(BUF_DEPTH + 1);
  localparam int JW = PW + CW;

  // configuration registers
  logic [lfw_pkg::FOLD_WIDTH_W-1:0] fold_width;
  logic [lfw_pkg::TAB_SPAN_W-1:0]   tab_span;

  // store write port, front to back
  logic          wr_en;
  logic [PW-1:0] wr_addr;
  logic [7:0]    wr_data;

  // line jobs: start of the oldest character and number of characters
  logic          job_push;
  logic [JW-1:0] job_in;
  logic          job_pop;
  logic          job_full;
  logic          job_empty;
  logic [JW-1:0] job_head;

  // one pulse per character the back end has read out of the store
  logic          rd_pulse;

  always_ff @(posedge clk) begin
    if (rst) begin
      fold_width <= lfw_pkg::FOLD_WIDTH_RESET;
      tab_span   <= lfw_pkg::TAB_SPAN_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        lfw_pkg::REG_FOLD_WIDTH: fold_width <= cfg_data[lfw_pkg::FOLD_WIDTH_W-1:0];
        lfw_pkg::REG_TAB_SPAN:   tab_span   <= cfg_data[lfw_pkg::TAB_SPAN_W-1:0];
        default: begin
          fold_width <= fold_width;
        end
      endcase
    end
  end

  // front: classifies bytes, writes the store, keeps column and blank mark
  lfw_front #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .fold_width   (fold_width),
    .tab_span     (tab_span),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .char_in      (char_in),
    .end_of_input (end_of_input),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .job_push     (job_push),
    .job_data     (job_in),
    .job_full     (job_full),
    .rd_pulse     (rd_pulse)
  );

  // queue of lines waiting to go out
  lfw_queue #(
    .WIDTH (JW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (job_push),
    .push_data (job_in),
    .pop       (job_pop),
    .full      (job_full),
    .empty     (job_empty),
    .head      (job_head)
  );

  // back: reads each line out of the store and appends the newline
  lfw_back #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .job_valid   (!job_empty),
    .job_data    (job_head),
    .job_pop     (job_pop),
    .rd_pulse    (rd_pulse),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .char_out    (char_out),
    .last_of_run (last_of_run)
  );

endmodule
`default_nettype wire

/* design/lfw_queue.sv */
`default_nettype none
module lfw_queue #(
  parameter int WIDTH = 13
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic                  full,
  output logic                  empty,
  output logic      [WIDTH-1:0] head
);

  logic [WIDTH-1:0] entry [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;

  logic do_push;
  logic do_pop;

  assign full    = (fill == 2'd2);
  assign empty   = (fill == 2'd0);
  assign head    = entry[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule
`default_nettype wire

/* design/lfw_front.sv */
`default_nettype none
module lfw_front #(
  parameter int BUF_DEPTH = lfw_pkg::DEF_BUF_DEPTH,
  localparam int PW = $clog2(BUF_DEPTH),
  localparam int CW = $clog2(BUF_DEPTH + 1)
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic [lfw_pkg::FOLD_WIDTH_W-1:0]  fold_width,
  input  wire logic [lfw_pkg::TAB_SPAN_W-1:0]    tab_span,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [7:0]                        char_in,
  input  wire logic                              end_of_input,
  output logic                                   wr_en,
  output logic      [PW-1:0]                     wr_addr,
  output logic      [7:0]                        wr_data,
  output logic                                   job_push,
  output logic      [PW+CW-1:0]                  job_data,
  input  wire logic                              job_full,
  input  wire logic                              rd_pulse
);

  localparam int AW = lfw_pkg::ARITH_W;
  localparam logic [AW-1:0] DEPTH_A = AW'(BUF_DEPTH);

  typedef enum logic {
    ST_ACCEPT,
    ST_TAB
  } state_t;

  state_t        state, state_next;
  logic [PW-1:0] wp, wp_next;
  logic [CW-1:0] count, count_next;
  logic          blank_valid, blank_valid_next;
  logic [CW-1:0] blank, blank_next;
  logic [CW-1:0] rem, rem_next;
  logic          tab_fold, tab_fold_next;
  logic [CW-1:0] unread, unread_next;

  logic [AW-1:0] width_a;
  logic [AW-1:0] tab_a;
  logic [AW-1:0] cnt_a;
  logic [AW-1:0] c1_a;
  logic [AW-1:0] start_a;
  logic [AW-1:0] blank_a;
  logic          blank_v;
  logic          has_blank;
  logic          space_ok;
  logic          accept;
  logic          last_space;
  logic [PW-1:0] wp_inc;
  logic [PW-1:0] start;
  logic [CW-1:0] job_len;

  // limits on the register values
  always_comb begin
    width_a = AW'(fold_width);
    if (width_a < AW'(lfw_pkg::WIDTH_MIN)) begin
      width_a = AW'(lfw_pkg::WIDTH_MIN);
    end
    if (width_a > DEPTH_A) begin
      width_a = DEPTH_A;
    end
    tab_a = AW'(tab_span);
    if (tab_a < AW'(lfw_pkg::TAB_MIN)) begin
      tab_a = AW'(lfw_pkg::TAB_MIN);
    end
    if (tab_a > AW'(lfw_pkg::TAB_MAX)) begin
      tab_a = AW'(lfw_pkg::TAB_MAX);
    end
  end

  assign cnt_a    = AW'(count);
  assign c1_a     = cnt_a + AW'(1);
  assign space_ok = (AW'(unread) + cnt_a) < DEPTH_A;
  assign wp_inc   = (wp == PW'(BUF_DEPTH - 1)) ? '0 : wp + PW'(1);
  assign in_ready = (state == ST_ACCEPT) && !job_full && space_ok;
  assign accept   = in_valid && in_ready;
  assign last_space = (rem == CW'(1));

  // oldest pending character sits count entries behind the write pointer
  always_comb begin
    start_a = AW'(wp) + DEPTH_A - cnt_a;
    if (start_a >= DEPTH_A) begin
      start_a = start_a - DEPTH_A;
    end
    start = PW'(start_a);
  end

  assign job_data = {start, job_len};
  assign wr_addr  = wp;

  always_comb begin
    state_next       = state;
    wp_next          = wp;
    count_next       = count;
    blank_valid_next = blank_valid;
    blank_next       = blank;
    rem_next         = rem;
    tab_fold_next    = tab_fold;
    wr_en            = 1'b0;
    wr_data          = char_in;
    job_push         = 1'b0;
    job_len          = count;
    blank_v          = blank_valid;
    blank_a          = AW'(blank);
    has_blank        = 1'b0;

    case (state)
      ST_ACCEPT: begin
        if (accept) begin
          if (end_of_input || char_in == lfw_pkg::CH_NEWLINE) begin
            job_push         = (count != '0);
            count_next       = '0;
            blank_valid_next = 1'b0;
          end else if (char_in == lfw_pkg::CH_TAB) begin
            if (cnt_a + tab_a >= width_a) begin
              if (cnt_a < width_a) begin
                rem_next      = CW'(width_a - cnt_a);
                tab_fold_next = 1'b1;
                state_next    = ST_TAB;
              end else begin
                // already at the width: emit without padding
                job_push         = 1'b1;
                count_next       = '0;
                blank_valid_next = 1'b0;
              end
            end else begin
              rem_next      = CW'(tab_a);
              tab_fold_next = 1'b0;
              state_next    = ST_TAB;
            end
          end else begin
            wr_en   = 1'b1;
            wp_next = wp_inc;
            if (char_in == lfw_pkg::CH_SPACE) begin
              blank_v = 1'b1;
              blank_a = c1_a;
            end
            if (c1_a >= width_a) begin
              has_blank        = blank_v && (blank_a <= c1_a);
              job_push         = 1'b1;
              job_len          = has_blank ? CW'(blank_a) : CW'(c1_a);
              count_next       = has_blank ? CW'(c1_a - blank_a) : '0;
              blank_valid_next = 1'b0;
            end else begin
              count_next       = CW'(c1_a);
              blank_next       = CW'(blank_a);
              blank_valid_next = blank_v;
            end
          end
        end
      end
      ST_TAB: begin
        if (space_ok && !(last_space && tab_fold && job_full)) begin
          wr_en    = 1'b1;
          wr_data  = lfw_pkg::CH_SPACE;
          wp_next  = wp_inc;
          rem_next = rem - CW'(1);
          count_next = CW'(c1_a);
          if (last_space) begin
            state_next = ST_ACCEPT;
            if (tab_fold) begin
              job_push         = 1'b1;
              job_len          = CW'(c1_a);
              count_next       = '0;
              blank_valid_next = 1'b0;
            end else begin
              blank_next       = CW'(c1_a);
              blank_valid_next = 1'b1;
            end
          end
        end
      end
      default: begin
        state_next = ST_ACCEPT;
      end
    endcase

    unread_next = unread + (job_push ? job_len : '0) - (rd_pulse ? CW'(1) : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_ACCEPT;
      wp          <= '0;
      count       <= '0;
      blank_valid <= 1'b0;
      blank       <= '0;
      rem         <= '0;
      tab_fold    <= 1'b0;
      unread      <= '0;
    end else begin
      state       <= state_next;
      wp          <= wp_next;
      count       <= count_next;
      blank_valid <= blank_valid_next;
      blank       <= blank_next;
      rem         <= rem_next;
      tab_fold    <= tab_fold_next;
      unread      <= unread_next;
    end
  end

endmodule
`default_nettype wire

/* design/lfw_back.sv */
`default_nettype none
module lfw_back #(
  parameter int BUF_DEPTH = lfw_pkg::DEF_BUF_DEPTH,
  localparam int PW = $clog2(BUF_DEPTH),
  localparam int CW = $clog2(BUF_DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [PW-1:0]    wr_addr,
  input  wire logic [7:0]       wr_data,
  input  wire logic             job_valid,
  input  wire logic [PW+CW-1:0] job_data,
  output logic                  job_pop,
  output logic                  rd_pulse,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic      [7:0]       char_out,
  output logic                  last_of_run
);

  logic [7:0]    line_store [BUF_DEPTH];
  logic [7:0]    rd_q;

  logic          busy;
  logic [PW-1:0] ptr;
  logic [CW-1:0] rem;
  logic          a_valid;
  logic          a_nl;

  logic          b_load;
  logic          a_adv;
  logic          issue;
  logic [PW-1:0] ptr_inc;

  assign b_load   = a_valid && (!out_valid || out_ready);
  assign a_adv    = !a_valid || b_load;
  assign issue    = busy && a_adv;
  assign rd_pulse = issue && (rem != '0);
  assign job_pop  = !busy && job_valid;
  assign ptr_inc  = (ptr == PW'(BUF_DEPTH - 1)) ? '0 : ptr + PW'(1);

  // store: one write port from the front, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_store[wr_addr] <= wr_data;
    end
    if (rd_pulse) begin
      rd_q <= line_store[ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (b_load) begin
      char_out    <= a_nl ? lfw_pkg::CH_NEWLINE : rd_q;
      last_of_run <= a_nl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      ptr       <= '0;
      rem       <= '0;
      a_valid   <= 1'b0;
      a_nl      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (job_pop) begin
        busy <= 1'b1;
        ptr  <= job_data[PW+CW-1:CW];
        rem  <= job_data[CW-1:0];
      end else if (issue) begin
        if (rem != '0) begin
          ptr <= ptr_inc;
          rem <= rem - CW'(1);
        end else begin
          busy <= 1'b0;
        end
      end
      if (a_adv) begin
        a_valid <= issue;
        a_nl    <= (rem == '0);
      end
      if (b_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire
